// File: design/maf_pkg.sv
// ----------------------------------------------------------------------------
// maf_pkg
// Shared types and fixed constants of the moving average filter.
// ----------------------------------------------------------------------------
package maf_pkg;

   // Width of the window length register.
   localparam int WIN_BITS = 7;

   // Window length after reset, before clamping to the ring depth.
   localparam int WINDOW_RESET = 50;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_OUTPUT
   } maf_state_type;

endpackage

// File: design/moving_average_filter_unit.sv
// ----------------------------------------------------------------------------
// moving_average_filter_unit
// Boxcar moving average over a ring of past samples held in block memory.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out. Each input sample updates a
// running sum over the most recent csr_window_length samples (fewer while
// the window fills after reset or after a window write) and the result is
// that sum divided by the number of samples in the window, truncated toward
// zero. A transaction is accepted only when the unit is idle. The
// synchronous ring read is issued at the accepting edge; then the update
// state updates the sum and writes the sample back to the ring, the divide
// state runs the radix-2 restoring divider over all quotient bits, and the
// output state loads the output register. The unit is idle again once the
// result is loaded and takes no new sample before that; the divider is the
// longest step. The output register holds a finished result while
// rsp_stall is high, so the next sample is taken and worked on in the
// meantime; only a second finished result waits for the first to go out.
// Writing csr_window_length (0 is taken as 1, values above RING_DEPTH as
// RING_DEPTH) restarts the fill phase; it must only be written while no
// transaction is in flight. The ring memory needs no clearing pass: an
// entry is read only after it has been rewritten since the last restart.
// ----------------------------------------------------------------------------
module moving_average_filter_unit #(
   parameter int RING_DEPTH  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          csr_write_enable,
   input  logic [maf_pkg::WIN_BITS-1:0]  csr_window_length,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_mean_out
);

   localparam int WB        = maf_pkg::WIN_BITS;
   localparam int PTR_BITS  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   // Longest window the register can ask for.
   localparam int MAX_WIN   = (RING_DEPTH < (2 ** WB) - 1) ? RING_DEPTH : (2 ** WB) - 1;
   // Signed sum of up to MAX_WIN samples.
   localparam int SUM_BITS  = SAMPLE_BITS + $clog2(MAX_WIN);
   localparam int CNT_BITS  = $clog2(SUM_BITS + 1);
   localparam int WIN_INIT  = (maf_pkg::WINDOW_RESET > RING_DEPTH) ?
                              RING_DEPTH : maf_pkg::WINDOW_RESET;

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   maf_pkg::maf_state_type state_ff, state_in;

   logic [WB-1:0]                window_ff, window_in;
   logic [WB-1:0]                fill_ff, fill_in;
   logic [PTR_BITS-1:0]          wp_ff, wp_in;
   logic signed [SUM_BITS-1:0]   sum_ff, sum_in;

   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;

   // Divider
   logic [SUM_BITS-1:0]          quo_ff, quo_in;
   logic [WB-1:0]                rem_ff, rem_in;
   logic [CNT_BITS-1:0]          cnt_ff, cnt_in;
   logic                         neg_ff, neg_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_mean_ff, rsp_mean_in;

   // Sample ring
   logic signed [SAMPLE_BITS-1:0] ring [RING_DEPTH];

   // ---------------------------------------------------------------------
   // Datapath helpers
   // ---------------------------------------------------------------------
   logic                         req_accept;
   logic                         rsp_accept;
   logic [PTR_BITS-1:0]          wp_eff;
   logic                         window_full;
   logic [WB-1:0]                win_clamped;
   logic [WB:0]                  rem_shift;
   logic                         rem_ge;
   logic [SUM_BITS-1:0]          sum_mag;
   logic [SUM_BITS-1:0]          quo_signed;
   logic                         div_done;
   logic                         out_free;

   assign req_accept  = req_valid && !req_stall;
   assign rsp_accept  = rsp_valid_ff && !rsp_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // Defensive wrap of the write pointer against the active window.
   assign wp_eff      = (int'(wp_ff) >= int'(window_ff)) ? '0 : wp_ff;
   assign window_full = (fill_ff >= window_ff);

   always_comb begin
      if (csr_window_length == '0) begin
         win_clamped = WB'(1);
      end else if (int'(csr_window_length) > RING_DEPTH) begin
         win_clamped = WB'(RING_DEPTH);
      end else begin
         win_clamped = csr_window_length;
      end
   end

   // Restoring divider step: one quotient bit per cycle, MSB first.
   assign rem_shift  = {rem_ff, quo_ff[SUM_BITS-1]};
   assign rem_ge     = (rem_shift >= {1'b0, fill_ff});
   assign div_done   = (cnt_ff == CNT_BITS'(SUM_BITS - 1));

   assign sum_mag    = sum_ff[SUM_BITS-1] ? SUM_BITS'(-sum_ff) : SUM_BITS'(sum_ff);
   assign quo_signed = neg_ff ? SUM_BITS'(-quo_ff) : quo_ff;

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         maf_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = maf_pkg::ST_UPDATE;
            end
         end
         maf_pkg::ST_UPDATE: begin
            state_in = maf_pkg::ST_DIVIDE;
         end
         maf_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = maf_pkg::ST_OUTPUT;
            end
         end
         maf_pkg::ST_OUTPUT: begin
            if (out_free) begin
               state_in = maf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = maf_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Outputs and datapath updates
   // ---------------------------------------------------------------------
   always_comb begin
      req_stall    = (state_ff != maf_pkg::ST_IDLE);
      window_in    = window_ff;
      fill_in      = fill_ff;
      wp_in        = wp_ff;
      sum_in       = sum_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_accept;
      rsp_mean_in  = rsp_mean_ff;

      unique case (state_ff)
         maf_pkg::ST_IDLE: begin
            // window writes take effect only here and are ignored in other states
            if (csr_write_enable) begin
               window_in = win_clamped;
               fill_in   = '0;
               wp_in     = '0;
               sum_in    = '0;
            end
         end
         maf_pkg::ST_UPDATE: begin
            // rd_data_ff holds the oldest sample of a full window
            if (window_full) begin
               sum_in  = sum_ff + SUM_BITS'(sample_ff) - SUM_BITS'(rd_data_ff);
               fill_in = window_ff;
            end else begin
               sum_in  = sum_ff + SUM_BITS'(sample_ff);
               fill_in = fill_ff + WB'(1);
            end
            if (int'(wp_eff) + 1 >= int'(window_ff)) begin
               wp_in = '0;
            end else begin
               wp_in = wp_eff + PTR_BITS'(1);
            end
         end
         maf_pkg::ST_DIVIDE: begin
            if (cnt_ff == '0) begin
               // first step: take the sign from the settled sum; bits shift in from here on
               neg_in = sum_ff[SUM_BITS-1];
            end
            quo_in = {quo_ff[SUM_BITS-2:0], rem_ge};
            rem_in = rem_ge ? WB'(rem_shift - {1'b0, fill_ff}) : WB'(rem_shift);
            cnt_in = cnt_ff + CNT_BITS'(1);
         end
         maf_pkg::ST_OUTPUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = SAMPLE_BITS'(quo_signed);
            end
         end
         default: begin
         end
      endcase

      // Divider operands are loaded while the sum settles.
      if (state_ff == maf_pkg::ST_UPDATE) begin
         quo_in = SUM_BITS'(sum_in[SUM_BITS-1] ? -sum_in : sum_in);
         rem_in = '0;
         cnt_in = '0;
         neg_in = sum_in[SUM_BITS-1];
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= maf_pkg::ST_IDLE;
         window_ff    <= WB'(WIN_INIT);
         fill_ff      <= '0;
         wp_ff        <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         fill_ff      <= fill_in;
         wp_ff        <= wp_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
      rsp_mean_ff <= rsp_mean_in;
      if (req_accept) begin
         sample_ff <= req_sample_in;
      end
   end

   // Sample ring: read on accept, write back in the update cycle. The
   // sequencer keeps the two apart, so no forwarding is needed.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff <= ring[wp_eff];
      end
      if (state_ff == maf_pkg::ST_UPDATE) begin
         ring[wp_eff] <= sample_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_mean_out = rsp_mean_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_accept_to_update: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == maf_pkg::ST_UPDATE))
      else $error("accepted transaction did not enter the update cycle");

   a_fill_in_window: assert property (@(posedge clock) disable iff (reset)
      (fill_ff <= window_ff) && (int'(wp_ff) < int'(window_ff)))
      else $error("fill count or write pointer outside the window");

   a_window_range: assert property (@(posedge clock) disable iff (reset)
      (window_ff != '0) && (int'(window_ff) <= RING_DEPTH))
      else $error("window length out of range");

   a_result_from_output: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == maf_pkg::ST_OUTPUT))
      else $error("result loaded outside the output cycle");

   a_magnitude_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == maf_pkg::ST_OUTPUT) |->
         (quo_ff <= SUM_BITS'(sum_mag)))
      else $error("quotient exceeds dividend magnitude");

endmodule

// File: tb/tb_moving_average_filter_unit.sv
// ----------------------------------------------------------------------------
// tb_moving_average_filter_unit
// Self-checking bench for the boxcar moving average filter.
// ----------------------------------------------------------------------------
// A scoreboard object tracks the window, fill count and running sum, and
// queues one expected mean per accepted sample. Each mean that leaves the
// unit is compared with the oldest queued value. Directed samples cover the
// rails, truncation toward zero and the clamped window writes. Random
// phases then restart the window with assorted lengths under random idling
// on both channels, one idle-free phase and one long output hold-off.
// ----------------------------------------------------------------------------

class boxcar_mean_board;
   localparam int DEPTH = 64;
   localparam int IDX_BITS = $clog2(DEPTH);
   localparam int SUM_BITS = 22;

   logic signed [15:0]         history [DEPTH];
   logic signed [15:0]         pending_means [$];
   logic signed [SUM_BITS-1:0] window_sum;
   int                         span;
   int                         slot;
   int                         filled;
   int unsigned                noted;
   int unsigned                checked;
   int unsigned                failures;

   function new();
      noted    = 0;
      checked  = 0;
      failures = 0;
      set_window(7'(maf_pkg::WINDOW_RESET));
   endfunction

   // 0 acts as 1, anything past the ring depth as the ring depth;
   // any write restarts the fill phase
   function void set_window(logic [maf_pkg::WIN_BITS-1:0] value);
      if (value == 0) begin
         span = 1;
      end else if (int'(value) > DEPTH) begin
         span = DEPTH;
      end else begin
         span = int'(value);
      end
      slot       = 0;
      filled     = 0;
      window_sum = '0;
   endfunction

   function void take_sample(logic signed [15:0] sample);
      int quotient;
      if (slot >= span) slot = 0;
      if (filled >= span) begin
         window_sum = window_sum - history[slot[IDX_BITS-1:0]];
      end else begin
         filled++;
      end
      window_sum    = window_sum + sample;
      history[slot[IDX_BITS-1:0]] = sample;
      slot          = (slot + 1 >= span) ? 0 : slot + 1;
      // signed division truncates toward zero
      quotient = window_sum / filled;
      pending_means.push_back(quotient[15:0]);
      noted++;
   endfunction

   function void match_mean(logic signed [15:0] actual);
      logic signed [15:0] expected;
      if (pending_means.size() == 0) begin
         $error("mean_out: result with no sample pending, actual %0d", actual);
         failures++;
      end else begin
         expected = pending_means.pop_front();
         checked++;
         if (actual !== expected) begin
            $error("mean_out mismatch: expected %0d, actual %0d", expected, actual);
            failures++;
         end
      end
   endfunction

   function int pending();
      return pending_means.size();
   endfunction
endclass

module tb_moving_average_filter_unit;

   localparam int          WIN_BITS        = maf_pkg::WIN_BITS;
   localparam int          RING_DEPTH      = 64;
   localparam int          SAMPLE_BITS     = 16;
   localparam int          ITEM_TARGET     = 1300;
   localparam int          HOLD_OFF_CYCLES = 400;
   localparam int          DRAIN_CYCLES    = 40;   // longer than the unit's latency
   localparam longint      TIMEOUT_UNITS   = 64'd7_200_000;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7FFF;

   logic                          clock             = 1'b0;
   logic                          reset             = 1'b1;
   logic                          csr_write_enable  = 1'b0;
   logic [WIN_BITS-1:0]           csr_window_length = '0;
   logic                          req_valid         = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample_in     = '0;
   logic                          rsp_valid;
   logic                          rsp_stall         = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_mean_out;

   // no_idle and hold_off_request are shared with the receiver process.
   bit                            no_idle          = 1'b0;
   bit                            hold_off_request = 1'b0;
   int unsigned                   window_writes    = 0;

   boxcar_mean_board board = new();

   moving_average_filter_unit #(
      .RING_DEPTH  (RING_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_window_length (csr_window_length),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample_in     (req_sample_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_mean_out      (rsp_mean_out)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Input side. Called at a falling edge; holds the sample until the
   // transaction goes through at a rising edge, then returns at the next
   // falling edge with valid still high so back-to-back samples need no
   // drop of valid.
   // ---------------------------------------------------------------------
   task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] sample);
      req_valid     = 1'b1;
      req_sample_in = sample;
      do @(posedge clock); while (req_stall);
      board.take_sample(sample);
      @(negedge clock);
   endtask

   // Sender pause: nothing offered until every queued mean has come back.
   task automatic wait_drained();
      req_valid = 1'b0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   // Only called with the unit idle; the register takes the value at the
   // rising edge in between.
   task automatic write_window(input logic [WIN_BITS-1:0] value);
      csr_write_enable  = 1'b1;
      csr_window_length = value;
      @(negedge clock);
      csr_write_enable  = 1'b0;
      board.set_window(value);
      window_writes++;
   endtask

   // One fill-and-slide phase. With rails set the window sees a run of
   // negative full-scale samples and then a run of positive ones, which
   // drives the running sum to both ends of its range once the window holds
   // 64 samples. Otherwise a mix of rails, near-zero values (where the
   // truncation direction shows) and full random samples.
   task automatic run_phase(input int count, input bit rails);
      logic signed [SAMPLE_BITS-1:0] sample;
      for (int i = 0; i < count; i++) begin
         if (rails) begin
            sample = (i < count / 2) ? SAMPLE_MIN : SAMPLE_MAX;
         end else begin
            case ($urandom_range(9)) inside
               0:       sample = SAMPLE_MIN;
               1:       sample = SAMPLE_MAX;
               [2:3]:   sample = SAMPLE_BITS'(int'($urandom_range(8)) - 4);
               default: sample = SAMPLE_BITS'($urandom);
            endcase
         end
         push_sample(sample);
         // gap lengths up to past the divider time so that idle stretches
         // end at every point of the unit's work
         if (!no_idle && $urandom_range(99) < 12) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 30)) @(negedge clock);
         end
      end
      wait_drained();
   endtask

   // ---------------------------------------------------------------------
   // Output side. Checks at the rising edge, sets the stall at the falling
   // edge. Short stall bursts at random (about one cycle in eight), and a
   // long hold-off on request, counted here.
   // ---------------------------------------------------------------------
   initial begin
      int hold_left;
      int burst_left;
      hold_left  = 0;
      burst_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) board.match_mean(rsp_mean_out);
         if (hold_off_request) begin
            hold_left        = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
         end
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else if (burst_left > 0) begin
            rsp_stall = 1'b1;
            burst_left--;
         end else if (!no_idle && $urandom_range(99) == 0) begin
            rsp_stall  = 1'b1;
            burst_left = $urandom_range(24);
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      logic [WIN_BITS-1:0] raw_window;
      int                  phase;

      // sync reset held from time zero, released at a falling edge
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Reset window (50), still filling: rails, a sum that leaves the
      // sample range before division, and negative sums that must
      // truncate toward zero rather than floor.
      push_sample(SAMPLE_MAX);
      push_sample(SAMPLE_MAX);
      push_sample(SAMPLE_MIN);
      push_sample(SAMPLE_MIN);
      push_sample(SAMPLE_MIN);
      push_sample(-16'sd1);
      push_sample(16'sd1);
      push_sample(16'sd0);
      push_sample(-16'sd7);
      wait_drained();

      // A zero write acts as a window of one: the mean is the sample.
      write_window('0);
      push_sample(SAMPLE_MIN);
      push_sample(SAMPLE_MAX);
      push_sample(-16'sd1);
      push_sample(16'sd0);
      wait_drained();

      // All-ones write clamps to the ring depth; -1/2 and -2/3 give 0.
      write_window('1);
      push_sample(16'sd1);
      push_sample(-16'sd2);
      push_sample(-16'sd1);
      wait_drained();

      // Restart with the reset value, then a full 64-sample window of each
      // rail to reach both ends of the running sum.
      write_window(WIN_BITS'(maf_pkg::WINDOW_RESET));
      push_sample(-16'sd3);
      wait_drained();
      write_window(WIN_BITS'(RING_DEPTH));
      run_phase(140, 1'b1);

      // Random phases: each starts with a window write (sometimes the same
      // value again, sometimes zero or past the ring depth) and runs long
      // enough for the window to fill and the ring to wrap.
      phase      = 0;
      raw_window = WIN_BITS'(RING_DEPTH);
      while (board.noted < ITEM_TARGET) begin
         case ($urandom_range(7))
            0:       raw_window = WIN_BITS'(1);
            1:       raw_window = WIN_BITS'(2);
            2:       raw_window = WIN_BITS'(RING_DEPTH);
            3:       raw_window = '0;
            4:       raw_window = WIN_BITS'($urandom_range(RING_DEPTH + 1, 127));
            5:       raw_window = raw_window;   // restart with an unchanged value
            default: raw_window = WIN_BITS'($urandom_range(1, RING_DEPTH - 1));
         endcase
         write_window(raw_window);
         no_idle = (phase == 2);
         // receiver holds off while the sender keeps offering, so the
         // unit fills its output register and stalls the input
         if (phase == 4) hold_off_request = 1'b1;
         run_phase(board.span + $urandom_range(4, board.span + 20), 1'b0);
         phase++;
      end
      no_idle = 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (board.pending() != 0) begin
         $error("mean_out: %0d expected results never arrived", board.pending());
         board.failures++;
      end

      $display("Covered %0d samples and %0d checked means over %0d window writes.",
               board.noted, board.checked, window_writes);
      $display("Windows 1 to 64 incl. zero and oversize writes, rail sums, %0d-cycle hold-off.",
               HOLD_OFF_CYCLES);
      if (board.failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #(TIMEOUT_UNITS);
      $display("Regression FAIL");
      $finish;
   end

endmodule
